// ===== hw/rtl/gpps_pkg.sv =====
// shared constants and controller/datapath command and status types
// for the goldbach prime pair search; no dependencies
`default_nettype none

package gpps_pkg;

    // data width of the number and of both primes
    localparam int unsigned WIDTH = 32;
    // bits of the divider step counter
    localparam int unsigned CNT_W = $clog2(WIDTH);
    // first candidate and first trial divisor; smallest value with a pair
    localparam logic [WIDTH-1:0] TWO = WIDTH'(2);
    localparam logic [WIDTH-1:0] FOUR = WIDTH'(4);

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word, candidate back to two
        logic test_init;  // pick number under test, divisor back to two
        logic test_sel;   // 0: test candidate, 1: test value minus candidate
        logic div_start;  // load divider with number under test
        logic div_step;   // one restoring division step
        logic d_inc;      // next trial divisor
        logic i_next;     // next candidate (2, 3, 5, 7, 9, ...)
        logic out_load;   // capture result into the output register
        logic out_found;  // result carries a pair
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic lt_four;    // value below four
        logic odd;        // value is odd
        logic i_ge_v;     // candidate has reached or run past the value
        logic n_lt2;      // number under test is 0 or 1
        logic div_last;   // last division step in progress
        logic d_gt_q;     // divisor above quotient: no divisor left to try
        logic rem_zero;   // remainder zero: divisor found
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/gpps_intf.sv =====
// valid/ready channel interfaces for the goldbach prime pair search
// depends on gpps_pkg
`default_nettype none

interface gpps_in_if
    import gpps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface gpps_out_if
    import gpps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] prime_low;
    logic [WIDTH-1:0] prime_high;
    logic             found;

    modport source (output valid, output prime_low, output prime_high, output found,
                    input ready);
    modport sink (input valid, input prime_low, input prime_high, input found,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gpps_datapath.sv =====
// datapath: value, candidate, trial divisor, restoring divider, result registers
// depends on gpps_pkg
`default_nettype none

module gpps_datapath
    import gpps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [WIDTH-1:0] i_value,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    output logic [WIDTH-1:0]      o_prime_low,
    output logic [WIDTH-1:0]      o_prime_high,
    output logic                  o_found
);

    logic [WIDTH-1:0] r_value;
    logic [WIDTH-1:0] r_i;
    logic [WIDTH-1:0] r_n;
    logic [WIDTH-1:0] r_d;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_lo;
    logic [WIDTH-1:0] r_hi;
    logic             r_found;

    logic [WIDTH-1:0] partner;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;
    logic             fits;

    assign partner = r_value - r_i;
    assign rem_sh  = {r_rem[WIDTH-1:0], r_q[WIDTH-1]};
    assign diff    = rem_sh - {1'b0, r_d};
    assign fits    = rem_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_i     <= TWO;
        end else if (i_cmd.i_next) begin
            r_i <= (r_i == TWO) ? WIDTH'(3) : r_i + WIDTH'(2);
        end

        if (i_cmd.test_init) begin
            r_n <= i_cmd.test_sel ? partner : r_i;
            r_d <= TWO;
        end else if (i_cmd.d_inc) begin
            r_d <= r_d + WIDTH'(1);
        end

        // restoring divide, one quotient bit a cycle
        if (i_cmd.div_start) begin
            r_q   <= r_n;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? diff : rem_sh;
            r_q   <= {r_q[WIDTH-2:0], fits};
            r_cnt <= r_cnt + CNT_W'(1);
        end

        if (i_cmd.out_load) begin
            r_lo    <= i_cmd.out_found ? r_i : '0;
            r_hi    <= i_cmd.out_found ? partner : '0;
            r_found <= i_cmd.out_found;
        end
    end

    assign o_sts.lt_four  = r_value < FOUR;
    assign o_sts.odd      = r_value[0];
    assign o_sts.i_ge_v   = r_i >= r_value;
    assign o_sts.n_lt2    = r_n < TWO;
    assign o_sts.div_last = r_cnt == CNT_W'(WIDTH - 1);
    assign o_sts.d_gt_q   = r_d > r_q;
    assign o_sts.rem_zero = r_rem == '0;

    assign o_prime_low  = r_lo;
    assign o_prime_high = r_hi;
    assign o_found      = r_found;

endmodule

`default_nettype wire

// ===== hw/rtl/gpps_ctrl.sv =====
// controller state machine: candidate loop, trial-division loop, output handshake
// depends on gpps_pkg
`default_nettype none

module gpps_ctrl
    import gpps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_NEXT  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_phase2, n_phase2;   // testing value minus candidate
    logic       r_found, n_found;
    logic       r_out_valid, n_out_valid;
    logic       test_done;
    logic       test_prime;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_phase2   = r_phase2;
        n_found    = r_found;
        test_done  = 1'b0;
        test_prime = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_sts.lt_four) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    // odd value: only the pair (2, value - 2) can work
                    o_cmd.test_init = 1'b1;
                    o_cmd.test_sel  = i_sts.odd;
                    n_phase2        = i_sts.odd;
                    n_state         = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.n_lt2) begin
                    test_done = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.d_gt_q) begin
                    test_done  = 1'b1;
                    test_prime = 1'b1;
                end else if (i_sts.rem_zero) begin
                    test_done = 1'b1;
                end else begin
                    o_cmd.d_inc = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_NEXT: begin
                if (i_sts.odd || i_sts.i_ge_v) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.test_init = 1'b1;
                    o_cmd.test_sel  = 1'b0;
                    n_phase2        = 1'b0;
                    n_state         = S_CHK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_found = r_found;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of one primality test
        if (test_done) begin
            if (test_prime && r_phase2) begin
                n_found = 1'b1;
                n_state = S_DONE;
            end else if (test_prime) begin
                o_cmd.test_init = 1'b1;
                o_cmd.test_sel  = 1'b1;
                n_phase2        = 1'b1;
                n_state         = S_CHK;
            end else begin
                o_cmd.i_next = 1'b1;
                n_state      = S_NEXT;
            end
        end
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase2    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase2    <= n_phase2;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while still pending");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_div_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> r_state == S_EVAL)
        else $error("division did not end in evaluation");

    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == S_SETUP)
        else $error("accepted word not set up");

endmodule

`default_nettype wire

// ===== hw/rtl/goldbach_prime_pair_search.sv =====
// top level of the goldbach prime pair search: controller plus datapath
// depends on gpps_pkg, gpps_intf, gpps_ctrl, gpps_datapath
`default_nettype none

// usage
// - input channel i_in: one word carries value; the block splits it into the
//   smallest prime prime_low and prime_high = value - prime_low, both prime
// - output channel o_out: one word per input word with prime_low, prime_high
//   and found; found is 0 and both primes 0 when no pair exists (value < 4,
//   or odd value whose value - 2 is not prime)
// - one word is searched at a time; i_in.ready is high only while idle
// - each primality test runs trial divisors 2, 3, 4, ... through a shared
//   restoring divider, one full division per divisor; a test of n tries
//   about min(smallest factor, sqrt(n)) divisors
// - per word the block loads the value, sets up, runs its tests, steps to the
//   next candidate for each one dropped and loads the result; candidates are
//   2, 3, 5, 7, 9, ... and value - candidate is tested only for prime ones
// - odd values need a single test of value - 2
// - the result sits in an output register, so a new word is taken while the
//   previous result is still unclaimed; a finished search waits until that
//   register is free when o_out.ready stays low
// - i_rst_n (synchronous, active low) returns to idle and drops o_out.valid;
//   no clearing pass is needed

module goldbach_prime_pair_search
    import gpps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gpps_in_if.sink   i_in,
    gpps_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing of candidates, tests and division steps
    gpps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic and result registers
    gpps_datapath u_dp (
        .i_clk        (i_clk),
        .i_value      (i_in.value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_prime_low  (o_out.prime_low),
        .o_prime_high (o_out.prime_high),
        .o_found      (o_out.found)
    );

endmodule

`default_nettype wire
